// ----- src/tsf_pkg.sv -----
// Package for the triangle scanline span fill block.
// Holds coordinate widths, phase codes, request mode codes and the edge type.
package tsf_pkg;

   localparam int COORD_BITS = 12;
   // Internal arithmetic width: coordinate differences and accumulated errors
   // need headroom beyond the coordinate width.
   localparam int WIDE_BITS  = COORD_BITS + 4;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [WIDE_BITS-1:0]  wide_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_UPPER = 3'b010,
      PH_LOWER = 3'b100
   } phase_type;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_SPAN = 1'b1;

   // Edge parameters produced by the setup unit.
   typedef struct packed {
      wide_type major;
      wide_type minor;
      logic     neg;
      logic     steep;
   } edge_type;

   // Pack the direction sign, the major/minor deltas and the steep flag of one edge.
   function automatic edge_type make_edge(wide_type dx, wide_type dy);
      edge_type e;
      wide_type mag;
      e.neg = dx[WIDE_BITS-1];
      mag = e.neg ? -dx : dx;
      if (dy > mag) begin
         e.major = dy;
         e.minor = mag;
         e.steep = 1'b1;
      end else begin
         e.major = mag;
         e.minor = dy;
         e.steep = 1'b0;
      end
      return e;
   endfunction

endpackage

// ----- src/triangle_scanline_span_fill_top.sv -----
// Top level of the triangle scanline span fill block: command port,
// vertex store, setup and the span sequencer driving edge walkers A and B.
// Depends on tsf_pkg and tsf_walker.
//
//   channel   handshake             payload
//   req_      start & !busy          req_mode, req_vertex_index, vertex x/y, color
//   rsp_      rsp_valid (one cycle)  span y, x start/end, color, last
//
// A load is accepted while idle; the load that completes the third vertex
// adds a sort/setup state with busy high.
// A span keeps busy high while either walker steps through its outer and inner
// states, then through the exit checks, emit, and the lower edge load at the end
// of the upper half; the span strobes the cycle after emit. Long x runs on
// shallow edges make a span take longest.
// Synchronous reset returns to idle with no vertex marked; busy stays high
// while a transaction is in flight. The receiver cannot stall results.
module triangle_scanline_span_fill_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_mode,
   input  logic [1:0]                req_vertex_index,
   input  tsf_pkg::coord_type        req_vertex_x,
   input  tsf_pkg::coord_type        req_vertex_y,
   input  logic [31:0]               req_fill_color,
   output logic                      rsp_valid,
   output tsf_pkg::coord_type        rsp_span_y,
   output tsf_pkg::coord_type        rsp_span_x_start,
   output tsf_pkg::coord_type        rsp_span_x_end,
   output logic [31:0]               rsp_span_color,
   output logic                      rsp_span_last
);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_SETUP = 8'b00000010,
      S_AOUT  = 8'b00000100,  // edge A outer step
      S_AIN   = 8'b00001000,  // edge A inner error loop
      S_BOUT  = 8'b00010000,
      S_BIN   = 8'b00100000,
      S_EMIT  = 8'b01000000,
      S_LOWER = 8'b10000000
   } seq_type;

   seq_type seq_ff, seq_in;
   tsf_pkg::phase_type phase_ff, phase_in;
   logic [2:0] mask_ff, mask_in;
   tsf_pkg::wide_type vx_ff [3];
   tsf_pkg::wide_type vy_ff [3];
   logic [31:0] color_ff;
   tsf_pkg::wide_type mid_x_ff, mid_y_ff, far_x_ff, far_y_ff, row_ff, row_in;
   tsf_pkg::wide_type cnt_ff, cnt_in, a0_ff, b0_ff;
   logic signed [1:0] abump_ff, abump_in, bbump_ff, bbump_in;
   logic out_a_ff, out_a_in;
   logic resp_ff, last_ff;
   tsf_pkg::wide_type rsp_y_ff, rsp_lo_ff, rsp_hi_ff;

   // Walker controls
   logic a_load, b_load, a_add, a_sub, a_step, a_bump, b_add, b_sub, b_step, b_bump;
   tsf_pkg::edge_type a_ledge, b_ledge, a_e, b_e;
   tsf_pkg::wide_type a_lx, b_lx, a_x, b_x, a_err, b_err;
   logic a_ge, b_ge;

   tsf_walker u_wa (.clock, .load(a_load), .load_edge(a_ledge), .load_x(a_lx),
      .add_minor(a_add), .sub_major(a_sub), .step_x(a_step), .bump_x(a_bump),
      .edge_q(a_e), .x_q(a_x), .err_q(a_err), .err_ge(a_ge));
   tsf_walker u_wb (.clock, .load(b_load), .load_edge(b_ledge), .load_x(b_lx),
      .add_minor(b_add), .sub_major(b_sub), .step_x(b_step), .bump_x(b_bump),
      .edge_q(b_e), .x_q(b_x), .err_q(b_err), .err_ge(b_ge));

   // Sort network on the stored vertices (three compare-swaps)
   tsf_pkg::wide_type sx [3];
   tsf_pkg::wide_type sy [3];
   always_comb begin
      tsf_pkg::wide_type t;
      t = '0;
      for (int k = 0; k < 3; k++) begin
         sx[k] = vx_ff[k];
         sy[k] = vy_ff[k];
      end
      if (sy[0] > sy[1]) begin
         t = sy[0]; sy[0] = sy[1]; sy[1] = t; t = sx[0]; sx[0] = sx[1]; sx[1] = t;
      end
      if (sy[0] > sy[2]) begin
         t = sy[0]; sy[0] = sy[2]; sy[2] = t; t = sx[0]; sx[0] = sx[2]; sx[2] = t;
      end
      if (sy[1] > sy[2]) begin
         t = sy[1]; sy[1] = sy[2]; sy[2] = t; t = sx[1]; sx[1] = sx[2]; sx[2] = t;
      end
   end

   logic accept, ld_ok;
   assign accept = start && !busy;
   assign ld_ok = accept && req_mode == tsf_pkg::REQ_LOAD && req_vertex_index != 2'd3;
   assign busy = seq_ff != S_IDLE;

   tsf_pkg::wide_type a_dir, b_dir, nxt_row;
   assign a_dir = a_e.neg ? -tsf_pkg::wide_type'(1) : tsf_pkg::wide_type'(1);
   assign b_dir = b_e.neg ? -tsf_pkg::wide_type'(1) : tsf_pkg::wide_type'(1);
   assign nxt_row = row_ff + tsf_pkg::wide_type'(1);

   // Sequencer
   always_comb begin
      seq_in = seq_ff;
      phase_in = phase_ff;
      mask_in = mask_ff;
      row_in = row_ff;
      cnt_in = cnt_ff;
      abump_in = abump_ff;
      bbump_in = bbump_ff;
      out_a_in = out_a_ff;
      a_load = 1'b0; b_load = 1'b0;
      a_add = 1'b0; a_sub = 1'b0; a_step = 1'b0; a_bump = 1'b0;
      b_add = 1'b0; b_sub = 1'b0; b_step = 1'b0; b_bump = 1'b0;
      a_ledge = tsf_pkg::make_edge(far_x_ff - mid_x_ff, far_y_ff - mid_y_ff);
      a_lx = mid_x_ff;
      b_ledge = tsf_pkg::make_edge(sx[2] - sx[0], sy[2] - sy[0]);
      b_lx = sx[0];
      unique case (seq_ff)
         S_IDLE: begin
            if (ld_ok) begin
               phase_in = tsf_pkg::PH_IDLE;
               mask_in = mask_ff | (3'b001 << req_vertex_index);
               if ((mask_ff | (3'b001 << req_vertex_index)) == 3'b111) begin
                  mask_in = 3'b000;
                  seq_in = S_SETUP;
               end
            end else if (accept && req_mode == tsf_pkg::REQ_SPAN
                         && phase_ff != tsf_pkg::PH_IDLE) begin
               abump_in = '0;
               bbump_in = '0;
               seq_in = S_AOUT;
            end
         end
         S_SETUP: begin
            row_in = sy[0];
            cnt_in = '0;
            b_load = 1'b1;
            a_load = 1'b1;
            a_lx = sx[0];
            if (sy[0] == sy[1]) begin
               a_ledge = tsf_pkg::make_edge(sx[2] - sx[1], sy[2] - sy[1]);
               a_lx = sx[1];
               phase_in = tsf_pkg::PH_LOWER;
            end else begin
               a_ledge = tsf_pkg::make_edge(sx[1] - sx[0], sy[1] - sy[0]);
               phase_in = tsf_pkg::PH_UPPER;
            end
            seq_in = S_IDLE;
         end
         S_AOUT: begin
            if (cnt_ff < a_e.major) begin
               if (phase_ff == tsf_pkg::PH_UPPER) cnt_in = cnt_ff + tsf_pkg::wide_type'(1);
               a_add = 1'b1;
               out_a_in = 1'b0;
               seq_in = S_AIN;
            end else begin
               seq_in = S_BOUT;
            end
         end
         S_AIN: begin
            if (a_ge && !out_a_ff) begin
               a_sub = 1'b1;
               if (a_e.steep) abump_in = a_e.neg ? 2'sd3 : 2'sd1;
               else out_a_in = 1'b1;
               // lower phase leaves the inner loop after one pass
               if (phase_ff == tsf_pkg::PH_LOWER) begin
                  seq_in = S_BOUT;
               end
               if (phase_ff == tsf_pkg::PH_UPPER && a_e.steep && !(a_err - a_e.major >= a_e.major))
                  seq_in = S_BOUT;
               if (!a_e.steep) seq_in = S_BOUT;
            end else if (out_a_ff || a_e.steep) begin
               seq_in = S_BOUT;
            end else begin
               a_step = 1'b1;
               if (phase_ff == tsf_pkg::PH_LOWER) cnt_in = cnt_ff + tsf_pkg::wide_type'(1);
               seq_in = S_AOUT;
            end
         end
         S_BOUT: begin
            if (phase_ff == tsf_pkg::PH_LOWER && b_x == far_x_ff) begin
               seq_in = S_EMIT;
            end else begin
               b_add = 1'b1;
               seq_in = S_BIN;
            end
         end
         S_BIN: begin
            if (b_ge) begin
               b_sub = 1'b1;
               if (b_e.steep) bbump_in = b_e.neg ? 2'sd3 : 2'sd1;
               if (!b_e.steep || !(b_err - b_e.major >= b_e.major)) seq_in = S_EMIT;
            end else if (b_e.steep) begin
               seq_in = S_EMIT;
            end else begin
               b_step = 1'b1;
               seq_in = S_BOUT;
            end
         end
         S_EMIT: begin
            a_step = !a_e.steep;
            a_bump = abump_ff != 2'sd0;
            b_step = !b_e.steep;
            b_bump = bbump_ff != 2'sd0;
            row_in = nxt_row;
            if (phase_ff == tsf_pkg::PH_UPPER) begin
               seq_in = (nxt_row == mid_y_ff || cnt_ff >= a_e.major) ? S_LOWER : S_IDLE;
            end else begin
               seq_in = S_IDLE;
               if (nxt_row > far_y_ff || cnt_ff + tsf_pkg::wide_type'(1) > a_e.major)
                  phase_in = tsf_pkg::PH_IDLE;
               else
                  cnt_in = cnt_ff + tsf_pkg::wide_type'(1);
            end
         end
         S_LOWER: begin
            a_load = 1'b1;
            cnt_in = '0;
            phase_in = tsf_pkg::PH_LOWER;
            seq_in = S_IDLE;
         end
         default: seq_in = S_IDLE;
      endcase
   end

   // Span bounds over start and end positions of both walkers
   tsf_pkg::wide_type lo, hi;
   always_comb begin
      lo = (a0_ff < b0_ff) ? a0_ff : b0_ff;
      hi = (a0_ff < b0_ff) ? b0_ff : a0_ff;
      if (a_x < lo) lo = a_x;
      if (b_x < lo) lo = b_x;
      if (a_x > hi) hi = a_x;
      if (b_x > hi) hi = b_x;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= S_IDLE;
         phase_ff <= tsf_pkg::PH_IDLE;
         mask_ff <= '0;
         resp_ff <= 1'b0;
         cnt_ff <= '0;
         row_ff <= '0;
         abump_ff <= '0;
         bbump_ff <= '0;
         out_a_ff <= 1'b0;
      end else begin
         seq_ff <= seq_in;
         phase_ff <= phase_in;
         mask_ff <= mask_in;
         resp_ff <= seq_ff == S_EMIT;
         cnt_ff <= cnt_in;
         row_ff <= row_in;
         abump_ff <= abump_in;
         bbump_ff <= bbump_in;
         out_a_ff <= out_a_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (ld_ok && seq_ff == S_IDLE) begin
         vx_ff[req_vertex_index] <= tsf_pkg::wide_type'(req_vertex_x);
         vy_ff[req_vertex_index] <= tsf_pkg::wide_type'(req_vertex_y);
         color_ff <= req_fill_color;
      end
      if (seq_ff == S_SETUP) begin
         mid_x_ff <= sx[1]; mid_y_ff <= sy[1];
         far_x_ff <= sx[2]; far_y_ff <= sy[2];
      end
      if (seq_ff == S_IDLE) begin
         a0_ff <= a_x;
         b0_ff <= b_x;
      end
      if (seq_ff == S_EMIT) begin
         rsp_y_ff <= row_ff;
         rsp_lo_ff <= lo;
         rsp_hi_ff <= hi;
         last_ff <= phase_ff == tsf_pkg::PH_LOWER
                    && (nxt_row > far_y_ff || cnt_ff + tsf_pkg::wide_type'(1) > a_e.major);
      end
   end

   assign rsp_valid = resp_ff;
   assign rsp_span_y = rsp_y_ff[tsf_pkg::COORD_BITS-1:0];
   assign rsp_span_x_start = rsp_lo_ff[tsf_pkg::COORD_BITS-1:0];
   assign rsp_span_x_end = rsp_hi_ff[tsf_pkg::COORD_BITS-1:0];
   assign rsp_span_color = color_ff;
   assign rsp_span_last = last_ff;

endmodule

// ----- src/tsf_walker.sv -----
// One Bresenham edge walker: holds x, error and deltas of one edge and does
// one inner step per cycle while the sequencer drives its step controls.
// Depends on tsf_pkg.
module tsf_walker (
   input  logic                clock,
   input  logic                load,
   input  tsf_pkg::edge_type   load_edge,
   input  tsf_pkg::wide_type   load_x,
   input  logic                add_minor,
   input  logic                sub_major,
   input  logic                step_x,
   input  logic                bump_x,
   output tsf_pkg::edge_type   edge_q,
   output tsf_pkg::wide_type   x_q,
   output tsf_pkg::wide_type   err_q,
   output logic                err_ge
);

   tsf_pkg::edge_type edge_ff, edge_in;
   tsf_pkg::wide_type x_ff, x_in, err_ff, err_in, dir;

   assign dir = edge_ff.neg ? -tsf_pkg::wide_type'(1) : tsf_pkg::wide_type'(1);

   // Error and position update
   always_comb begin
      edge_in = edge_ff;
      x_in = x_ff;
      err_in = err_ff;
      if (load) begin
         edge_in = load_edge;
         x_in = load_x;
         err_in = load_edge.major >>> 1;
      end else begin
         if (add_minor) err_in = err_ff + edge_ff.minor;
         else if (sub_major) err_in = err_ff - edge_ff.major;
         if (step_x && bump_x) x_in = x_ff + dir + dir;
         else if (step_x || bump_x) x_in = x_ff + dir;
      end
   end

   always_ff @(posedge clock) begin
      edge_ff <= edge_in;
      x_ff <= x_in;
      err_ff <= err_in;
   end

   assign edge_q = edge_ff;
   assign x_q = x_ff;
   assign err_q = err_ff;
   assign err_ge = err_ff >= edge_ff.major;

endmodule

// ----- sim/triangle_scanline_span_fill_top_test.sv -----
// Testbench for triangle_scanline_span_fill_top: loads triangles, requests spans
// and checks each span against an in-bench Bresenham span predictor.
// Depends on tsf_pkg and the RTL of the block.
`timescale 1ns / 100ps

module triangle_scanline_span_fill_top_test;

   typedef struct {
      tsf_pkg::coord_type y;
      tsf_pkg::coord_type xs;
      tsf_pkg::coord_type xe;
      logic [31:0]        color;
      logic               last;
   } span_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_mode;
   logic [1:0]         req_vertex_index;
   tsf_pkg::coord_type req_vertex_x;
   tsf_pkg::coord_type req_vertex_y;
   logic [31:0]        req_fill_color;
   logic               rsp_valid;
   tsf_pkg::coord_type rsp_span_y;
   tsf_pkg::coord_type rsp_span_x_start;
   tsf_pkg::coord_type rsp_span_x_end;
   logic [31:0]        rsp_span_color;
   logic               rsp_span_last;

   span_type    span_queue[$];
   int          err_count;
   int          burst_left;
   int          item_count;

   // predictor state
   int          vx[3], vy[3];
   logic [31:0] color_latch;
   logic [2:0]  loaded_slots;
   tsf_pkg::phase_type fill_phase;
   int          row_y, ax, bx, aerr, berr, amaj, amin, bmaj, bmin, adir, bdir;
   bit          asteep, bsteep;
   int          steps, mid_x, mid_y, far_x, far_y;

   triangle_scanline_span_fill_top u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_vertex_index(req_vertex_index),
      .req_vertex_x(req_vertex_x), .req_vertex_y(req_vertex_y),
      .req_fill_color(req_fill_color), .rsp_valid(rsp_valid),
      .rsp_span_y(rsp_span_y), .rsp_span_x_start(rsp_span_x_start),
      .rsp_span_x_end(rsp_span_x_end), .rsp_span_color(rsp_span_color),
      .rsp_span_last(rsp_span_last)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("triangle_scanline_span_fill_top_test: done, errors");
      $finish;
   end

   // ---------------- predictor ----------------
   task automatic clear_predictor();
      for (int k = 0; k < 3; k++) begin
         vx[k] = 0;
         vy[k] = 0;
      end
      color_latch = '0; loaded_slots = '0; fill_phase = tsf_pkg::PH_IDLE;
      row_y = 0; ax = 0; bx = 0; aerr = 0; berr = 0;
      amaj = 0; amin = 0; bmaj = 0; bmin = 0; adir = 1; bdir = 1;
      asteep = 0; bsteep = 0; steps = 0;
      mid_x = 0; mid_y = 0; far_x = 0; far_y = 0;
   endtask

   task automatic start_lower_half();
      int t;
      amaj = far_x - mid_x;
      adir = 1;
      if (amaj < 0) begin
         amaj = -amaj;
         adir = -1;
      end
      amin = far_y - mid_y;
      ax = mid_x;
      asteep = 0;
      if (amin > amaj) begin
         t = amin; amin = amaj; amaj = t; asteep = 1;
      end
      aerr = amaj / 2;
      steps = 0;
      fill_phase = tsf_pkg::PH_LOWER;
   endtask

   task automatic sort_and_setup();
      int x1, y1, x2, y2, x3, y3, t;
      x1 = vx[0]; y1 = vy[0]; x2 = vx[1]; y2 = vy[1]; x3 = vx[2]; y3 = vy[2];
      if (y1 > y2) begin t = y1; y1 = y2; y2 = t; t = x1; x1 = x2; x2 = t; end
      if (y1 > y3) begin t = y1; y1 = y3; y3 = t; t = x1; x1 = x3; x3 = t; end
      if (y2 > y3) begin t = y2; y2 = y3; y3 = t; t = x2; x2 = x3; x3 = t; end
      mid_x = x2; mid_y = y2; far_x = x3; far_y = y3;
      ax = x1; bx = x1; row_y = y1;
      amaj = x2 - x1; adir = 1;
      if (amaj < 0) begin amaj = -amaj; adir = -1; end
      amin = y2 - y1;
      bmaj = x3 - x1; bdir = 1;
      if (bmaj < 0) begin bmaj = -bmaj; bdir = -1; end
      bmin = y3 - y1;
      asteep = 0; bsteep = 0;
      if (amin > amaj) begin t = amin; amin = amaj; amaj = t; asteep = 1; end
      if (bmin > bmaj) begin t = bmin; bmin = bmaj; bmaj = t; bsteep = 1; end
      berr = bmaj / 2;
      if (y1 == y2) start_lower_half();
      else begin
         aerr = amaj / 2;
         steps = 0;
         fill_phase = tsf_pkg::PH_UPPER;
      end
   endtask

   // long edge walk to the end of the current row
   task automatic walk_long_edge(bit guarded, inout int bump);
      bit leave;
      while (!guarded || bx != far_x) begin
         leave = 0;
         berr += bmin;
         while (berr >= bmaj) begin
            berr -= bmaj;
            if (bsteep) bump = bdir;
            else begin
               leave = 1;
               break;
            end
         end
         if (leave || bsteep) break;
         bx += bdir;
      end
   endtask

   // apply one accepted transaction; returns 1 with the span if one results
   task automatic predict_span(input logic mode, input logic [1:0] idx,
                               input tsf_pkg::coord_type x, input tsf_pkg::coord_type y,
                               input logic [31:0] color,
                               output bit has_span, output span_type s);
      int a0, b0, lo, hi, abump, bbump, row;
      bit leave, last;
      has_span = 0;
      abump = 0; bbump = 0; last = 0;
      s = '{default: '0};
      if (mode == tsf_pkg::REQ_LOAD) begin
         if (idx == 2'd3) return;
         vx[idx] = x;
         vy[idx] = y;
         color_latch = color;
         fill_phase = tsf_pkg::PH_IDLE;
         loaded_slots[idx] = 1'b1;
         if (loaded_slots == 3'b111) begin
            loaded_slots = '0;
            sort_and_setup();
         end
         return;
      end
      if (fill_phase == tsf_pkg::PH_IDLE) return;
      a0 = ax; b0 = bx;
      if (fill_phase == tsf_pkg::PH_UPPER) begin
         while (steps < amaj) begin
            leave = 0;
            steps++;
            aerr += amin;
            while (aerr >= amaj) begin
               aerr -= amaj;
               if (asteep) abump = adir;
               else begin
                  leave = 1;
                  break;
               end
            end
            if (leave || asteep) break;
            ax += adir;
         end
         walk_long_edge(0, bbump);
      end else begin
         while (steps < amaj) begin
            leave = 0;
            aerr += amin;
            if (aerr >= amaj) begin
               aerr -= amaj;
               if (asteep) abump = adir;
               else leave = 1;
            end
            if (leave || asteep) break;
            ax += adir;
            steps++;
         end
         walk_long_edge(1, bbump);
      end
      lo = a0 < b0 ? a0 : b0;
      hi = a0 < b0 ? b0 : a0;
      if (ax < lo) lo = ax;
      if (bx < lo) lo = bx;
      if (ax > hi) hi = ax;
      if (bx > hi) hi = bx;
      row = row_y;
      if (!asteep) ax += adir;
      ax += abump;
      if (!bsteep) bx += bdir;
      bx += bbump;
      row_y++;
      if (fill_phase == tsf_pkg::PH_UPPER) begin
         if (row_y == mid_y || steps >= amaj) start_lower_half();
      end else begin
         if (row_y > far_y) last = 1;
         else begin
            steps++;
            if (steps > amaj) last = 1;
         end
         if (last) fill_phase = tsf_pkg::PH_IDLE;
      end
      has_span = 1;
      s.y = tsf_pkg::coord_type'(row);
      s.xs = tsf_pkg::coord_type'(lo);
      s.xe = tsf_pkg::coord_type'(hi);
      s.color = color_latch;
      s.last = last;
   endtask

   // ---------------- sender ----------------
   task automatic send_item(input logic mode, input logic [1:0] idx,
                            input tsf_pkg::coord_type x, input tsf_pkg::coord_type y,
                            input logic [31:0] color);
      bit has_span;
      span_type s;
      if (burst_left == 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat ($urandom_range(6)) @(negedge clock);
         burst_left = ($urandom_range(3) == 0) ? 200 : $urandom_range(1, 20);
      end else begin
         @(negedge clock);
      end
      burst_left--;
      start = 1'b1;
      req_mode = mode;
      req_vertex_index = idx;
      req_vertex_x = x;
      req_vertex_y = y;
      req_fill_color = color;
      do @(posedge clock); while (busy);
      predict_span(mode, idx, x, y, color, has_span, s);
      if (has_span) span_queue.push_back(s);
      item_count++;
   endtask

   task automatic drain_spans();
      @(negedge clock);
      start = 1'b0;
      while (span_queue.size() != 0) @(negedge clock);
      burst_left = 0;
   endtask

   task automatic load_triangle(input int x[3], input int y[3], input logic [31:0] color);
      int order[3];
      int j, t;
      order = '{0, 1, 2};
      for (int k = 2; k > 0; k--) begin
         j = $urandom_range(k);
         t = order[k]; order[k] = order[j]; order[j] = t;
      end
      for (int k = 0; k < 3; k++)
         send_item(tsf_pkg::REQ_LOAD, order[k][1:0], tsf_pkg::coord_type'(x[order[k]]),
                   tsf_pkg::coord_type'(y[order[k]]), color);
   endtask

   // request spans until the predictor says the triangle is done or the limit is reached
   task automatic fill_spans(input int limit);
      int n;
      n = 0;
      while (fill_phase != tsf_pkg::PH_IDLE && n < limit) begin
         send_item(tsf_pkg::REQ_SPAN, 2'($urandom), tsf_pkg::coord_type'($urandom),
                   tsf_pkg::coord_type'($urandom), $urandom);
         n++;
      end
   endtask

   // ---------------- checker ----------------
   always @(posedge clock) begin
      span_type e;
      if (!reset && rsp_valid) begin
         if (span_queue.size() == 0) begin
            $error("unexpected span y=%0d", rsp_span_y);
            err_count++;
         end else begin
            e = span_queue.pop_front();
            if (rsp_span_y !== e.y) begin
               $error("span_y exp %0d got %0d", e.y, rsp_span_y); err_count++;
            end
            if (rsp_span_x_start !== e.xs) begin
               $error("span_x_start exp %0d got %0d", e.xs, rsp_span_x_start);
               err_count++;
            end
            if (rsp_span_x_end !== e.xe) begin
               $error("span_x_end exp %0d got %0d", e.xe, rsp_span_x_end);
               err_count++;
            end
            if (rsp_span_color !== e.color) begin
               $error("span_color exp %h got %h", e.color, rsp_span_color);
               err_count++;
            end
            if (rsp_span_last !== e.last) begin
               $error("span_last exp %0b got %0b", e.last, rsp_span_last);
               err_count++;
            end
         end
      end
   end

   // ---------------- tests ----------------
   task automatic test_idle_requests();
      send_item(tsf_pkg::REQ_SPAN, 2'd0, 12'sd0, 12'sd0, 32'h0);
      send_item(tsf_pkg::REQ_LOAD, 2'd3, 12'sd5, 12'sd5, 32'hFFFF_FFFF);
      send_item(tsf_pkg::REQ_SPAN, 2'd3, -12'sd1, -12'sd1, 32'hFFFF_FFFF);
   endtask

   task automatic test_extremes();
      // full-range triangle, then full-width shallow edges, then flat top,
      // then flat bottom, then degenerate, then one near the largest y
      load_triangle('{-2048, 2047, 0}, '{-2048, -2048, 2047}, 32'hFFFF_FFFF);
      fill_spans(3);
      load_triangle('{-2048, 2047, 3}, '{-2048, -2040, -2030}, 32'hA5A5_5A5A);
      fill_spans(5000);
      drain_spans();
      load_triangle('{10, 20, 15}, '{-3, -3, 4}, 32'h0000_0001);
      fill_spans(100);
      load_triangle('{0, 8, -6}, '{0, 9, 9}, 32'h8000_0000);
      fill_spans(100);
      send_item(tsf_pkg::REQ_SPAN, 2'd1, 12'sd7, 12'sd7, 32'h1234_5678);
      load_triangle('{3, 3, 3}, '{7, 7, 7}, 32'h5555_AAAA);
      fill_spans(100);
      load_triangle('{-5, 30, 2}, '{2047, 2040, 2030}, 32'h0F0F_F0F0);
      fill_spans(100);
      drain_spans();
   endtask

   task automatic test_random_triangles(input int target);
      int x[3], y[3];
      int cx, cy, span;
      while (item_count < target) begin
         span = ($urandom_range(40) == 0) ? 100 : $urandom_range(1, 24);
         cx = $urandom_range(4095 - 2 * span) - 2048 + span;
         cy = $urandom_range(4095 - 2 * span) - 2048 + span;
         for (int k = 0; k < 3; k++) begin
            x[k] = cx + $urandom_range(2 * span) - span;
            y[k] = cy + $urandom_range(2 * span) - span;
         end
         if ($urandom_range(5) == 0) y[1] = y[0];
         load_triangle(x, y, $urandom);
         case ($urandom_range(7))
            0: fill_spans($urandom_range(3));
            1: begin
               fill_spans(10000);
               send_item(tsf_pkg::REQ_SPAN, 2'($urandom), tsf_pkg::coord_type'($urandom),
                         tsf_pkg::coord_type'($urandom), $urandom);
            end
            2: send_item(tsf_pkg::REQ_LOAD, 2'd3, tsf_pkg::coord_type'($urandom),
                         tsf_pkg::coord_type'($urandom), $urandom);
            default: fill_spans(10000);
         endcase
         if ($urandom_range(30) == 0) drain_spans();
      end
   endtask

   initial begin
      err_count = 0;
      burst_left = 0;
      item_count = 0;
      clear_predictor();
      start = 1'b0;
      req_mode = tsf_pkg::REQ_LOAD;
      req_vertex_index = '0;
      req_vertex_x = '0;
      req_vertex_y = '0;
      req_fill_color = '0;
      reset = 1'b1;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      test_idle_requests();
      test_extremes();
      test_random_triangles(item_count + 780);

      drain_spans();
      while (busy) @(negedge clock);
      repeat (20) @(negedge clock);
      if (err_count == 0)
         $display("triangle_scanline_span_fill_top_test: done, clean");
      else
         $display("triangle_scanline_span_fill_top_test: done, errors");
      $finish;
   end

endmodule
